// ===== design/ntsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ntsp_pkg
// Shared types, codes and sizes of the note-triggered sample player.
// ----------------------------------------------------------------------------
package ntsp_pkg;

  // Sizes
  localparam int VOICES       = 4;
  localparam int SAMPLE_DEPTH = 65536;  // power of two
  localparam int SAMPLE_BITS  = 16;

  localparam int SETUP_REGS = 4;
  localparam int CFG_IDX_W  = $clog2(SETUP_REGS);
  localparam int SETUP_W    = 46;
  localparam int ADDR_W     = $clog2(SAMPLE_DEPTH);
  localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int POS_W      = 16;
  localparam int LEN_W      = 17;
  localparam int SMP_W      = 16;
  localparam int WORD_W     = 2 * SMP_W;
  localparam int OUT_W      = 19;
  localparam int ACC_W      = OUT_W + 1;
  localparam int MASK_W     = 4;
  localparam int MASK_VOICES = (VOICES < MASK_W) ? VOICES : MASK_W;
  localparam int QDEPTH     = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(65536);

  // Keep only the top SAMPLE_BITS bits of a stored sample
  localparam logic [SMP_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'({SMP_W{1'b1}} << (SMP_W - SAMPLE_BITS));

  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(1 << (OUT_W - 1));

  // Input operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_NOTE  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // Note event codes
  typedef enum logic [1:0] {
    NOTE_OFF   = 2'd0,
    NOTE_ON    = 2'd1,
    NOTE_OTHER = 2'd2
  } note_ev_e;

  // Command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_NOTE,
    CMD_WRITE
  } cmd_kind_e;

  // Sequencer states of the back end
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MOD,
    ST_DRAIN,
    ST_EMIT
  } back_state_e;

  // Packed voice setup: enable at bit 0, length at the top
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [15:0]      start;
    logic [6:0]       note;
    logic [3:0]       channel;
    logic             rpt;
    logic             enable;
  } setup_t;

  typedef struct packed {
    cmd_kind_e                kind;
    logic                     note_on;
    logic [VOICES-1:0]        match;
    logic [15:0]              addr;
    logic [WORD_W-1:0]        word;
    logic signed [SMP_W-1:0]  left;
    logic signed [SMP_W-1:0]  right;
  } cmd_t;

endpackage

// ===== design/ntsp_if.sv =====
// ----------------------------------------------------------------------------
// ntsp_if
// Valid/ready channels carrying input requests and mixed output samples.
// ----------------------------------------------------------------------------
interface ntsp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] in_left;
  logic signed [15:0] in_right;
  logic [3:0]         midi_channel;
  logic [6:0]         note_number;
  logic [1:0]         note_event;
  logic [15:0]        mem_address;
  logic signed [15:0] mem_left;
  logic signed [15:0] mem_right;

  modport source (
    output valid, operation, in_left, in_right, midi_channel, note_number,
           note_event, mem_address, mem_left, mem_right,
    input  ready
  );
  modport sink (
    input  valid, operation, in_left, in_right, midi_channel, note_number,
           note_event, mem_address, mem_left, mem_right,
    output ready
  );
endinterface

interface ntsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] out_left;
  logic signed [18:0] out_right;
  logic [3:0]         playing_mask;

  modport source (
    output valid, out_left, out_right, playing_mask,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, playing_mask,
    output ready
  );
endinterface

// ===== design/ntsp_front.sv =====
// ----------------------------------------------------------------------------
// ntsp_front
// Accept input requests, drop the ones with no effect, decode the rest.
// ----------------------------------------------------------------------------
module ntsp_front (
  ntsp_in_if.sink                           in_i,
  input  ntsp_pkg::setup_t [ntsp_pkg::VOICES-1:0] setup_i,
  output logic                              push_valid_o,
  output ntsp_pkg::cmd_t                    push_cmd_o,
  input  logic                              push_ready_i
);

  logic keep;

  assign in_i.ready = push_ready_i;

  always_comb begin
    keep                = 1'b0;
    push_cmd_o.kind     = ntsp_pkg::CMD_TICK;
    push_cmd_o.note_on  = (in_i.note_event == ntsp_pkg::NOTE_ON);
    push_cmd_o.addr     = in_i.mem_address;
    push_cmd_o.word     = {in_i.mem_right & ntsp_pkg::SAMPLE_MASK,
                           in_i.mem_left & ntsp_pkg::SAMPLE_MASK};
    push_cmd_o.left     = in_i.in_left;
    push_cmd_o.right    = in_i.in_right;
    for (int v = 0; v < ntsp_pkg::VOICES; v++) begin
      push_cmd_o.match[v] = setup_i[v].enable &&
                            (setup_i[v].channel == in_i.midi_channel) &&
                            (setup_i[v].note == in_i.note_number);
    end
    case (in_i.operation)
      ntsp_pkg::OP_TICK: begin
        keep = 1'b1;
        push_cmd_o.kind = ntsp_pkg::CMD_TICK;
      end
      ntsp_pkg::OP_NOTE: begin
        // other message kinds fall through with no effect
        keep = (in_i.note_event == ntsp_pkg::NOTE_OFF) ||
               (in_i.note_event == ntsp_pkg::NOTE_ON);
        push_cmd_o.kind = ntsp_pkg::CMD_NOTE;
      end
      ntsp_pkg::OP_WRITE: begin
        keep = 1'b1;
        push_cmd_o.kind = ntsp_pkg::CMD_WRITE;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_valid_o = in_i.valid && keep;

endmodule

// ===== design/ntsp_queue.sv =====
// ----------------------------------------------------------------------------
// ntsp_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ntsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  ntsp_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output ntsp_pkg::cmd_t pop_cmd_o,
  input  logic           pop_ready_i
);

  localparam int PTR_W = (ntsp_pkg::QDEPTH > 1) ? $clog2(ntsp_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(ntsp_pkg::QDEPTH + 1);

  ntsp_pkg::cmd_t   slot_q [ntsp_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(ntsp_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(ntsp_pkg::QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(ntsp_pkg::QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/ntsp_rem.sv =====
// ----------------------------------------------------------------------------
// ntsp_rem
// Bit-serial remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntsp_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ntsp_pkg::LEN_W-1:0] dividend_i,
  input  logic [ntsp_pkg::LEN_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [ntsp_pkg::LEN_W-1:0] rem_o
);

  localparam int W     = ntsp_pkg::LEN_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     num_q, den_q, rem_q, rem_d;
  logic [W:0]       trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = W'(trial - {1'b0, den_q});
    end else begin
      rem_d = W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/ntsp_back.sv =====
// ----------------------------------------------------------------------------
// ntsp_back
// Execute queued commands: memory writes, note events and mixing ticks.
// ----------------------------------------------------------------------------
module ntsp_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ntsp_pkg::setup_t [ntsp_pkg::VOICES-1:0] setup_i,
  input  logic                                    pop_valid_i,
  input  ntsp_pkg::cmd_t                          pop_cmd_i,
  output logic                                    pop_ready_o,
  ntsp_out_if.source                              out_o
);

  localparam int ACC_W = ntsp_pkg::ACC_W;
  localparam int SMP_W = ntsp_pkg::SMP_W;
  localparam int LEN_W = ntsp_pkg::LEN_W;
  localparam int POS_W = ntsp_pkg::POS_W;

  function automatic logic signed [ACC_W-1:0] sx(input logic [SMP_W-1:0] s);
    return {{(ACC_W - SMP_W){s[SMP_W-1]}}, s};
  endfunction

  function automatic logic signed [ntsp_pkg::OUT_W-1:0] sat(
      input logic signed [ACC_W-1:0] a);
    if (a > ntsp_pkg::OUT_MAX) begin
      return ntsp_pkg::OUT_W'(ntsp_pkg::OUT_MAX);
    end else if (a < ntsp_pkg::OUT_MIN) begin
      return ntsp_pkg::OUT_W'(ntsp_pkg::OUT_MIN);
    end
    return ntsp_pkg::OUT_W'(a);
  endfunction

  ntsp_pkg::back_state_e state_q, state_d;

  logic [ntsp_pkg::VIDX_W-1:0]             vidx_q, vidx_d;
  logic [ntsp_pkg::VOICES-1:0]             playing_q, playing_d;
  logic [ntsp_pkg::VOICES-1:0][POS_W-1:0]  pos_q, pos_d;
  logic signed [ACC_W-1:0]                 acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic                                    rd_vld_q, rd_issue;

  logic [ntsp_pkg::WORD_W-1:0] mem [ntsp_pkg::SAMPLE_DEPTH];
  logic [ntsp_pkg::WORD_W-1:0] rdata_q;
  logic [ntsp_pkg::ADDR_W-1:0] mem_addr;
  logic                        mem_we;

  logic                               out_valid_q, out_load;
  logic signed [ntsp_pkg::OUT_W-1:0]  out_l_q, out_r_q;
  logic [ntsp_pkg::MASK_W-1:0]        mask_q, mask_d;

  ntsp_pkg::setup_t   cur;
  logic [LEN_W-1:0]   len_eff, np, newpos, rem_res;
  logic [LEN_W:0]     twice_len;
  logic               rem_start, rem_done, advance, apply;

  // current voice setup and its effective length
  always_comb begin
    cur = setup_i[vidx_q];
    if (cur.length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cur.length > ntsp_pkg::LEN_MAX) begin
      len_eff = ntsp_pkg::LEN_MAX;
    end else begin
      len_eff = cur.length;
    end
    twice_len = {len_eff, 1'b0};
    np        = {1'b0, pos_q[vidx_q]} + LEN_W'(1);
  end

  ntsp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (np),
    .divisor_i  (len_eff),
    .done_o     (rem_done),
    .rem_o      (rem_res)
  );

  always_comb begin
    state_d     = state_q;
    vidx_d      = vidx_q;
    playing_d   = playing_q;
    pos_d       = pos_q;
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = ntsp_pkg::ADDR_W'({1'b0, cur.start} + {1'b0, pos_q[vidx_q]});
    rd_issue    = 1'b0;
    rem_start   = 1'b0;
    advance     = 1'b0;
    apply       = 1'b0;
    newpos      = np;
    out_load    = 1'b0;
    mask_d      = '0;
    for (int i = 0; i < ntsp_pkg::MASK_VOICES; i++) begin
      mask_d[i] = playing_q[i];
    end

    // fold in the word read in the previous cycle
    acc_l_d = acc_l_q + (rd_vld_q ? sx(rdata_q[SMP_W-1:0]) : '0);
    acc_r_d = acc_r_q + (rd_vld_q ? sx(rdata_q[2*SMP_W-1:SMP_W]) : '0);

    case (state_q)
      ntsp_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          case (pop_cmd_i.kind)
            ntsp_pkg::CMD_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = ntsp_pkg::ADDR_W'(pop_cmd_i.addr);
            end
            ntsp_pkg::CMD_NOTE: begin
              for (int v = 0; v < ntsp_pkg::VOICES; v++) begin
                if (pop_cmd_i.match[v]) begin
                  pos_d[v]     = '0;
                  playing_d[v] = pop_cmd_i.note_on;
                end
              end
            end
            ntsp_pkg::CMD_TICK: begin
              acc_l_d = sx(pop_cmd_i.left);
              acc_r_d = sx(pop_cmd_i.right);
              vidx_d  = '0;
              state_d = ntsp_pkg::ST_TICK;
            end
            default: ;
          endcase
        end
      end
      ntsp_pkg::ST_TICK: begin
        if (!cur.enable) begin
          playing_d[vidx_q] = 1'b0;
          pos_d[vidx_q]     = '0;
          advance           = 1'b1;
        end else if (playing_q[vidx_q]) begin
          rd_issue = 1'b1;
          if (np < len_eff) begin
            newpos = np;
            apply  = 1'b1;
          end else if ({1'b0, np} < twice_len) begin
            newpos = np - len_eff;
            apply  = 1'b1;
          end else begin
            // position ran past a shortened length: take the full remainder
            rem_start = 1'b1;
            state_d   = ntsp_pkg::ST_MOD;
          end
        end else begin
          advance = 1'b1;
        end
      end
      ntsp_pkg::ST_MOD: begin
        if (rem_done) begin
          newpos = rem_res;
          apply  = 1'b1;
        end
      end
      ntsp_pkg::ST_DRAIN: begin
        state_d = ntsp_pkg::ST_EMIT;
      end
      ntsp_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ntsp_pkg::ST_IDLE;
        end
      end
      default: state_d = ntsp_pkg::ST_IDLE;
    endcase

    if (apply) begin
      pos_d[vidx_q] = POS_W'(newpos);
      if (newpos == '0 && !cur.rpt) begin
        playing_d[vidx_q] = 1'b0;
      end
      advance = 1'b1;
    end
    if (advance) begin
      if (vidx_q == ntsp_pkg::VIDX_W'(ntsp_pkg::VOICES - 1)) begin
        state_d = ntsp_pkg::ST_DRAIN;
      end else begin
        vidx_d  = vidx_q + ntsp_pkg::VIDX_W'(1);
        state_d = ntsp_pkg::ST_TICK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntsp_pkg::ST_IDLE;
      vidx_q      <= '0;
      playing_q   <= '0;
      pos_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vidx_q    <= vidx_d;
      playing_q <= playing_d;
      pos_q     <= pos_d;
      rd_vld_q  <= rd_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
    if (out_load) begin
      out_l_q <= sat(acc_l_q);
      out_r_q <= sat(acc_r_q);
      mask_q  <= mask_d;
    end
  end

  // single-port sample memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= pop_cmd_i.word;
    end
    rdata_q <= mem[mem_addr];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_left     = out_l_q;
  assign out_o.out_right    = out_r_q;
  assign out_o.playing_mask = mask_q;

endmodule

// ===== design/note_triggered_sample_player_top.sv =====
// ----------------------------------------------------------------------------
// note_triggered_sample_player_top
// Multi-voice stereo sample player: note events start and stop voices, each
// audio tick mixes the current word of every playing voice into the input.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Carries
//  in_i      in   valid/ready   tick samples, note events, sample writes
//  out_o     out  valid/ready   mixed left/right and playing mask, one per tick
//  cfg_*     in   write enable  voice setup registers 0..3
//
//  A sample write or note event is carried out as the back end takes it from
//  the queue. An audio tick steps through the voices in turn: the single-port
//  sample memory gives one read per playing voice, then a drain state folds in
//  the last read and an emit state loads the output register. A voice whose
//  position lies far past a shortened length also waits for the serial remainder.
//  Reset clears voice state, setup, queue and output valid; sample memory
//  holds no defined content until written and is never swept.
//  A two-entry queue parts the front from the back, and the output register
//  lets the back finish a tick while the previous result still waits.
//
module note_triggered_sample_player_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ntsp_in_if.sink                           in_i,
  ntsp_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [ntsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ntsp_pkg::SETUP_W-1:0]      cfg_data_i
);

  ntsp_pkg::setup_t                          setup_q [ntsp_pkg::SETUP_REGS];
  ntsp_pkg::setup_t [ntsp_pkg::VOICES-1:0]   voice_setup;

  logic           push_valid, push_ready, pop_valid, pop_ready;
  ntsp_pkg::cmd_t push_cmd, pop_cmd;

  // Hold setup registers; ignore indexes with no voice behind them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ntsp_pkg::SETUP_REGS; r++) begin
        setup_q[r] <= '0;
      end
    end else if (cfg_we_i && (int'(cfg_index_i) < ntsp_pkg::VOICES)) begin
      setup_q[cfg_index_i] <= ntsp_pkg::setup_t'(cfg_data_i);
    end
  end

  // Voices without a register stay disabled
  for (genvar v = 0; v < ntsp_pkg::VOICES; v++) begin : g_setup
    if (v < ntsp_pkg::SETUP_REGS) begin : g_reg
      assign voice_setup[v] = setup_q[v];
    end else begin : g_zero
      assign voice_setup[v] = '0;
    end
  end

  // Front: decode and drop requests that do nothing
  ntsp_front u_front (
    .in_i         (in_i),
    .setup_i      (voice_setup),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  ntsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // Back: memory, voice positions and the mixer
  ntsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .setup_i     (voice_setup),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
